>>> design/uer_pkg.sv
// Shared widths, register indexes and scaling constants for the echo ranger.
`default_nettype none

package uer_pkg;

    localparam int unsigned PERIOD_W   = 20;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned ERR_W      = 16;
    localparam int unsigned CM_W       = 8;
    localparam int unsigned TRIG_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // distance_q8 = (width * 4496) >> 10, i.e. width * 0.0343 / 2 in Q8.8
    localparam int unsigned SCALE_W     = 13;
    localparam int unsigned SCALE_NUM   = 4496;
    localparam int unsigned SCALE_SHIFT = 10;
    localparam int unsigned PROD_W      = COUNT_W + SCALE_W;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_TRIGGER_LEN = 3'd1,
        CFG_ECHO_TMO    = 3'd2,
        CFG_PERIOD      = 3'd3,
        CFG_MIN_CM      = 3'd4,
        CFG_MAX_CM      = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> design/uer_ifs.sv
// Valid/ready channel interfaces: echo sample in, ranging result out, register writes.
`default_nettype none

interface uer_echo_if import uer_pkg::*; ();
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_result_if import uer_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              result_valid;
    logic [DIST_W-1:0] distance_q8;
    logic              in_range;
    logic              timed_out;
    logic [ERR_W-1:0]  error_total;
    logic              ok_led;
    logic              error_led;

    modport source (
        output valid, output trigger_level, output result_valid, output distance_q8,
        output in_range, output timed_out, output error_total, output ok_led,
        output error_led, input ready
    );
    modport sink (
        input valid, input trigger_level, input result_valid, input distance_q8,
        input in_range, input timed_out, input error_total, input ok_led,
        input error_led, output ready
    );
endinterface

interface uer_cfg_if import uer_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/ultrasonic_echo_ranger.sv
// Ultrasonic time-of-flight ranger: trigger sequencing, echo timing and distance scaling.
// The result beat for an echo tick appears in the cycle after that tick's beat is taken.
// One tick beat per cycle unless a result waits; the single output register decouples the two sides.
// Per-tick work (sequencer step, 16x13 scale multiply, range compare) is combinational.
// Reset (synchronous, i_rst_n low): sequencer idle, counters and flags zero, LEDs off,
// registers back to defaults (enabled, 10-tick trigger, 10000-tick timeout, 250000 period).
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    uer_echo_if.sink     i_echo,
    uer_result_if.source o_result,
    uer_cfg_if.sink      i_cfg
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_FALL = 2'd3
    } t_phase;

    // configuration registers
    logic                r_enable;
    logic [TRIG_W-1:0]   r_trigger_len;
    logic [COUNT_W-1:0]  r_echo_tmo;
    logic [PERIOD_W-1:0] r_period_us;
    logic [CM_W-1:0]     r_min_cm;
    logic [CM_W-1:0]     r_max_cm;

    // measurement state
    t_phase              r_phase,      n_phase;
    logic [PERIOD_W-1:0] r_period_cnt, n_period_cnt;
    logic [COUNT_W-1:0]  r_phase_cnt,  n_phase_cnt;
    logic [DIST_W-1:0]   r_last_dist,  n_last_dist;
    logic [ERR_W-1:0]    r_err_cnt,    n_err_cnt;
    logic                r_in_range,   n_in_range;
    logic                r_timed_out,  n_timed_out;
    logic                r_ok_led,     n_ok_led;
    logic                r_err_led,    n_err_led;

    // output register (per-tick fields; the rest come straight from state)
    logic                r_out_valid;
    logic                r_out_trig,   n_out_trig;
    logic                r_out_rv,     n_out_rv;

    logic                in_beat;
    logic [PERIOD_W-1:0] period_inc;
    logic [COUNT_W-1:0]  phase_inc;
    logic                do_finish;
    logic                fin_timeout;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-SCALE_SHIFT-1:0] dist_raw;
    logic [DIST_W-1:0]   dist_sat;
    logic                dist_good;

    // Take a new tick whenever the output slot is empty or being drained.
    assign i_echo.ready = !r_out_valid || o_result.ready;
    assign in_beat      = i_echo.valid && i_echo.ready;
    assign i_cfg.ready  = 1'b1;

    // Period counter saturates; in the echo waits the phase counter is never advanced past the timeout.
    assign period_inc = (r_period_cnt != PERIOD_MAX) ? r_period_cnt + 1'b1 : r_period_cnt;
    assign phase_inc  = r_phase_cnt + 1'b1;

    // Echo width to Q8.8 centimetres, saturate, then check against the window.
    assign product  = PROD_W'(r_phase_cnt) * PROD_W'(SCALE_NUM);
    assign dist_raw = product[PROD_W-1:SCALE_SHIFT];
    assign dist_sat = (dist_raw > PROD_W'(DIST_W'('1))) ? '1 : dist_raw[DIST_W-1:0];
    assign dist_good = (dist_sat >= {r_min_cm, 8'd0}) && (dist_sat <= {r_max_cm, 8'd0});

    always_comb begin
        n_phase      = r_phase;
        n_period_cnt = period_inc;
        n_phase_cnt  = r_phase_cnt;
        n_last_dist  = r_last_dist;
        n_err_cnt    = r_err_cnt;
        n_in_range   = r_in_range;
        n_timed_out  = r_timed_out;
        n_ok_led     = r_ok_led;
        n_err_led    = r_err_led;
        n_out_trig   = 1'b0;
        n_out_rv     = 1'b0;
        do_finish    = 1'b0;
        fin_timeout  = 1'b0;

        if (!r_enable) begin
            // drop any measurement in flight, no result
            n_phase     = PH_IDLE;
            n_phase_cnt = '0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (period_inc >= r_period_us) begin
                        n_period_cnt = '0;
                        n_out_trig   = 1'b1;
                        // a trigger length of zero or one ends the pulse on this tick
                        if (r_trigger_len <= TRIG_W'(1)) begin
                            n_phase     = PH_RISE;
                            n_phase_cnt = '0;
                        end else begin
                            n_phase     = PH_TRIG;
                            n_phase_cnt = COUNT_W'(1);
                        end
                    end
                end
                PH_TRIG: begin
                    n_out_trig = 1'b1;
                    if (phase_inc >= COUNT_W'(r_trigger_len)) begin
                        n_phase     = PH_RISE;
                        n_phase_cnt = '0;
                    end else begin
                        n_phase_cnt = phase_inc;
                    end
                end
                PH_RISE: begin
                    if (i_echo.echo_level) begin
                        // first high tick counts toward the width
                        if (r_echo_tmo == '0) begin
                            do_finish   = 1'b1;
                            fin_timeout = 1'b1;
                        end else begin
                            n_phase     = PH_FALL;
                            n_phase_cnt = COUNT_W'(1);
                        end
                    end else if (r_phase_cnt >= r_echo_tmo) begin
                        do_finish   = 1'b1;
                        fin_timeout = 1'b1;
                    end else begin
                        n_phase_cnt = phase_inc;
                    end
                end
                PH_FALL: begin
                    if (!i_echo.echo_level) begin
                        do_finish = 1'b1;
                    end else if (r_phase_cnt >= r_echo_tmo) begin
                        do_finish   = 1'b1;
                        fin_timeout = 1'b1;
                    end else begin
                        n_phase_cnt = phase_inc;
                    end
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_phase_cnt = '0;
                end
            endcase
        end

        if (do_finish) begin
            n_phase     = PH_IDLE;
            n_phase_cnt = '0;
            n_out_rv    = 1'b1;
            n_timed_out = fin_timeout;
            if (fin_timeout) begin
                n_last_dist = '0;
                n_in_range  = 1'b0;
                n_ok_led    = 1'b0;
                n_err_led   = 1'b1;
                n_err_cnt   = r_err_cnt + 1'b1;
            end else begin
                n_last_dist = dist_sat;
                n_in_range  = dist_good;
                n_ok_led    = dist_good;
                n_err_led   = !dist_good;
                if (!dist_good) begin
                    n_err_cnt = r_err_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_trigger_len <= TRIG_W'(10);
            r_echo_tmo    <= COUNT_W'(10000);
            r_period_us   <= PERIOD_W'(250000);
            r_min_cm      <= CM_W'(5);
            r_max_cm      <= CM_W'(25);
            r_phase       <= PH_IDLE;
            r_period_cnt  <= '0;
            r_phase_cnt   <= '0;
            r_last_dist   <= '0;
            r_err_cnt     <= '0;
            r_in_range    <= 1'b0;
            r_timed_out   <= 1'b0;
            r_ok_led      <= 1'b0;
            r_err_led     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_trig    <= 1'b0;
            r_out_rv      <= 1'b0;
        end else begin
            // register writes; indexes past the list are ignored
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ENABLE:      r_enable      <= i_cfg.data[0];
                    CFG_TRIGGER_LEN: r_trigger_len <= i_cfg.data[TRIG_W-1:0];
                    CFG_ECHO_TMO:    r_echo_tmo    <= i_cfg.data[COUNT_W-1:0];
                    CFG_PERIOD:      r_period_us   <= i_cfg.data[PERIOD_W-1:0];
                    CFG_MIN_CM:      r_min_cm      <= i_cfg.data[CM_W-1:0];
                    CFG_MAX_CM:      r_max_cm      <= i_cfg.data[CM_W-1:0];
                    default: ;
                endcase
            end

            // advance on every tick beat; hold while the result waits
            if (in_beat) begin
                r_phase      <= n_phase;
                r_period_cnt <= n_period_cnt;
                r_phase_cnt  <= n_phase_cnt;
                r_last_dist  <= n_last_dist;
                r_err_cnt    <= n_err_cnt;
                r_in_range   <= n_in_range;
                r_timed_out  <= n_timed_out;
                r_ok_led     <= n_ok_led;
                r_err_led    <= n_err_led;
                r_out_trig   <= n_out_trig;
                r_out_rv     <= n_out_rv;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // State only moves with a new beat, so the status fields hold while stalled.
    assign o_result.valid         = r_out_valid;
    assign o_result.trigger_level = r_out_trig;
    assign o_result.result_valid  = r_out_rv;
    assign o_result.distance_q8   = r_last_dist;
    assign o_result.in_range      = r_in_range;
    assign o_result.timed_out     = r_timed_out;
    assign o_result.error_total   = r_err_cnt;
    assign o_result.ok_led        = r_ok_led;
    assign o_result.error_led     = r_err_led;

endmodule

`default_nettype wire

>>> design/uer_checker.sv
// Port-level checker for the echo ranger, bound to the top level.
`default_nettype none

module uer_checker import uer_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire              i_trigger_level,
    input wire              i_result_valid,
    input wire [DIST_W-1:0] i_distance_q8,
    input wire              i_in_range,
    input wire              i_timed_out,
    input wire [ERR_W-1:0]  i_error_total,
    input wire              i_ok_led,
    input wire              i_error_led
);

    // a stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_distance_q8)
            && $stable(i_error_total) && $stable(i_result_valid)
            && $stable(i_trigger_level))
        else $error("result beat changed while stalled");

    // a timeout clears the distance and can never count as in range
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_timed_out |-> i_distance_q8 == '0 && !i_in_range)
        else $error("timed-out result shows a distance or in-range");

    // the ok LED follows the range flag, and both LEDs are never lit together
    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_ok_led == i_in_range && !(i_ok_led && i_error_led))
        else $error("LED state disagrees with range flag");

    // a finished measurement lights exactly one LED
    a_finish_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_valid |-> i_ok_led != i_error_led)
        else $error("finished measurement without exactly one LED");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_trigger_level (o_result.trigger_level),
    .i_result_valid  (o_result.result_valid),
    .i_distance_q8   (o_result.distance_q8),
    .i_in_range      (o_result.in_range),
    .i_timed_out     (o_result.timed_out),
    .i_error_total   (o_result.error_total),
    .i_ok_led        (o_result.ok_led),
    .i_error_led     (o_result.error_led)
);

`default_nettype wire

>>> tb/sv/uer_tick_checker.sv
// Result checker for the echo ranger: predicts every tick's result beat and compares it.
module uer_tick_checker import uer_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    uer_echo_if   i_echo,
    uer_result_if i_result,
    uer_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_TRIG, SEQ_RISE, SEQ_FALL} seq_e;

    typedef struct packed {
        logic              trigger_level;
        logic              result_valid;
        logic [DIST_W-1:0] distance_q8;
        logic              in_range;
        logic              timed_out;
        logic [ERR_W-1:0]  error_total;
        logic              ok_led;
        logic              error_led;
    } reading_t;

    // register copies
    logic                enable_r;
    logic [TRIG_W-1:0]   trig_len_r;
    logic [COUNT_W-1:0]  tmo_r;
    logic [PERIOD_W-1:0] period_r;
    logic [CM_W-1:0]     min_cm_r;
    logic [CM_W-1:0]     max_cm_r;

    // sequencer copy
    seq_e                seq;
    logic [PERIOD_W-1:0] since_start;
    int unsigned         seq_count;
    logic [DIST_W-1:0]   last_dist;
    logic [ERR_W-1:0]    err_count;
    logic                in_range_f;
    logic                timed_out_f;
    logic                ok_f;
    logic                err_f;

    reading_t readings_due[$];
    int       fail_total = 0;
    int       due_count  = 0;
    int       beat_no    = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;

    function automatic void reset_ranger();
        enable_r    = 1'b1;
        trig_len_r  = 8'd10;
        tmo_r       = 16'd10000;
        period_r    = 20'd250000;
        min_cm_r    = 8'd5;
        max_cm_r    = 8'd25;
        seq         = SEQ_IDLE;
        since_start = '0;
        seq_count   = 0;
        last_dist   = '0;
        err_count   = '0;
        in_range_f  = 1'b0;
        timed_out_f = 1'b0;
        ok_f        = 1'b0;
        err_f       = 1'b0;
    endfunction

    // Close a measurement: scale the echo width to Q8.8 cm and grade it.
    function automatic void close_measurement(logic timeout, int unsigned width);
        int unsigned scaled;
        if (timeout) begin
            last_dist  = '0;
            in_range_f = 1'b0;
        end else begin
            scaled = (width * SCALE_NUM) >> SCALE_SHIFT;
            if (scaled > 32'h0000_FFFF) scaled = 32'h0000_FFFF;
            last_dist  = scaled[DIST_W-1:0];
            in_range_f = (scaled >= {min_cm_r, 8'h00}) && (scaled <= {max_cm_r, 8'h00});
        end
        timed_out_f = timeout;
        ok_f        = in_range_f;
        err_f       = !in_range_f;
        if (!in_range_f) err_count = err_count + 1'b1;
        seq       = SEQ_IDLE;
        seq_count = 0;
    endfunction

    // Advance one microsecond tick and return the result beat it produces.
    function automatic reading_t advance_ranger(logic echo);
        reading_t r;
        logic     trig = 1'b0;
        logic     done = 1'b0;
        if (since_start != PERIOD_MAX) since_start = since_start + 1'b1;
        if (!enable_r) begin
            seq       = SEQ_IDLE;
            seq_count = 0;
        end else begin
            case (seq)
                SEQ_IDLE: begin
                    if (since_start >= period_r) begin
                        since_start = '0;
                        trig        = 1'b1;
                        seq_count   = 0;
                        seq         = (trig_len_r <= 1) ? SEQ_RISE : SEQ_TRIG;
                        if (seq == SEQ_TRIG) seq_count = 1;
                    end
                end
                SEQ_TRIG: begin
                    trig      = 1'b1;
                    seq_count = seq_count + 1;
                    if (seq_count >= trig_len_r) begin
                        seq       = SEQ_RISE;
                        seq_count = 0;
                    end
                end
                SEQ_RISE: begin
                    if (echo) begin
                        // first high tick already counts toward the width
                        seq       = SEQ_FALL;
                        seq_count = 0;
                        if (tmo_r == 0) begin
                            close_measurement(1'b1, 0);
                            done = 1'b1;
                        end else begin
                            seq_count = 1;
                        end
                    end else if (seq_count >= tmo_r) begin
                        close_measurement(1'b1, 0);
                        done = 1'b1;
                    end else begin
                        seq_count = seq_count + 1;
                    end
                end
                default: begin
                    if (!echo) begin
                        close_measurement(1'b0, seq_count);
                        done = 1'b1;
                    end else if (seq_count >= tmo_r) begin
                        close_measurement(1'b1, 0);
                        done = 1'b1;
                    end else begin
                        seq_count = seq_count + 1;
                    end
                end
            endcase
        end
        r = {trig, done, last_dist, in_range_f, timed_out_f, err_count, ok_f, err_f};
        return r;
    endfunction

    function automatic string show(reading_t r);
        return $sformatf("trig %0b done %0b dist %h inrange %0b timeout %0b errs %h ok %0b err %0b",
                         r.trigger_level, r.result_valid, r.distance_q8, r.in_range,
                         r.timed_out, r.error_total, r.ok_led, r.error_led);
    endfunction

    always @(posedge i_clk) begin : watch
        reading_t got;
        reading_t want;
        if (!i_rst_n) begin
            reset_ranger();
            readings_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_ENABLE:      enable_r   = i_cfg.data[0];
                    CFG_TRIGGER_LEN: trig_len_r = i_cfg.data[TRIG_W-1:0];
                    CFG_ECHO_TMO:    tmo_r      = i_cfg.data[COUNT_W-1:0];
                    CFG_PERIOD:      period_r   = i_cfg.data[PERIOD_W-1:0];
                    CFG_MIN_CM:      min_cm_r   = i_cfg.data[CM_W-1:0];
                    CFG_MAX_CM:      max_cm_r   = i_cfg.data[CM_W-1:0];
                    default: ;
                endcase
            end
            if (i_echo.valid && i_echo.ready) begin
                readings_due.push_back(advance_ranger(i_echo.echo_level));
            end
            if (i_result.valid && i_result.ready) begin
                got = {i_result.trigger_level, i_result.result_valid, i_result.distance_q8,
                       i_result.in_range, i_result.timed_out, i_result.error_total,
                       i_result.ok_led, i_result.error_led};
                if (readings_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("ERROR beat %0d: result with no tick outstanding: %s",
                                 beat_no, show(got));
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("ERROR beat %0d mismatch", beat_no);
                            $display("  actual   %s", show(got));
                            $display("  expected %s", show(want));
                        end
                    end
                end
                beat_no++;
            end
        end
        due_count = readings_due.size();
    end

endmodule

>>> tb/sv/ultrasonic_echo_ranger_tb.sv
// Top of the echo ranger testbench: clock, reset, tick and register stimulus, verdict.
module ultrasonic_echo_ranger_tb import uer_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Which side of the channels inserts bubbles during a phase.
    typedef enum logic [1:0] {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_e;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    gap_mode_e gap_mode = GAP_NONE;
    int        ticks_sent = 0;
    int        fail_count;
    int        pending_n;

    uer_echo_if   echo_ch ();
    uer_result_if result_ch ();
    uer_cfg_if    cfg_ch ();

    ultrasonic_echo_ranger dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_echo   (echo_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    uer_tick_checker tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_echo       (echo_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_n)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: stall at the rate the current phase asks for, else keep ready high.
    always @(negedge i_clk) begin
        if (gap_mode == GAP_RECEIVER) begin
            result_ch.ready <= ($urandom_range(99) >= 71);
        end else if (gap_mode == GAP_BOTH) begin
            result_ch.ready <= ($urandom_range(99) >= 31);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Write one register. Valid stays high on return so back-to-back writes need no
    // bubble; on the last write drop valid and wait for another falling edge so the next
    // raise does not share a time step with the drop.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value,
                             input logic last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        if (last) begin
            cfg_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic program_ranger(input logic en, input int trig, input int tmo,
                                  input int period, input int min_cm, input int max_cm);
        write_reg(CFG_ENABLE,      CFG_DATA_W'(en),     1'b0);
        write_reg(CFG_TRIGGER_LEN, CFG_DATA_W'(trig),   1'b0);
        write_reg(CFG_ECHO_TMO,    CFG_DATA_W'(tmo),    1'b0);
        write_reg(CFG_PERIOD,      CFG_DATA_W'(period), 1'b0);
        write_reg(CFG_MIN_CM,      CFG_DATA_W'(min_cm), 1'b0);
        write_reg(CFG_MAX_CM,      CFG_DATA_W'(max_cm), 1'b1);
    endtask

    // Send one echo tick. Insert sender bubbles first, with junk on the echo pin while
    // valid is low. Valid is left high on return.
    task automatic send_tick(input logic level);
        int idle_pct;
        idle_pct = (gap_mode == GAP_SENDER) ? 71 : (gap_mode == GAP_BOTH) ? 31 : 0;
        while ($urandom_range(99) < idle_pct) begin
            echo_ch.valid      <= 1'b0;
            echo_ch.echo_level <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        echo_ch.valid      <= 1'b1;
        echo_ch.echo_level <= level;
        do @(posedge i_clk); while (!echo_ch.ready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic send_level(input logic level, input int count);
        repeat (count) send_tick(level);
    endtask

    // Send the low count bits of a pattern, most significant first.
    task automatic send_pattern(input logic [15:0] bits, input int count);
        for (int i = count - 1; i >= 0; i--) send_tick(bits[i]);
    endtask

    // Hold the sender off until every predicted beat has been seen, then let the
    // output register empty out.
    task automatic settle();
        echo_ch.valid <= 1'b0;
        while (pending_n != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          phase_no;
        int          kind;
        int          budget;
        int          start_ticks;
        int          random_start;
        int          pulse_cap;
        logic        en;
        int          trig;
        int          tmo;
        int          period;
        int          min_cm;
        int          max_cm;

        // Known values on every input from time zero.
        i_rst_n            = 1'b0;
        echo_ch.valid      = 1'b0;
        echo_ch.echo_level = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_ENABLE;
        cfg_ch.data        = '0;
        result_ch.ready    = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- Directed part -------------------------------------------------------
        // Reset settings: long period, so these ticks start nothing.
        send_pattern(16'b01, 2);
        settle();

        // Zero period, zero trigger length (acts as one tick), zero timeout: every
        // enabled idle tick starts, and the rise wait fails on its first tick, echo high or low.
        program_ranger(1'b1, 0, 0, 0, 0, 255);
        send_pattern(16'b1100, 4);
        settle();

        // Short clean pulse: two-tick trigger, three-tick echo, in range, then a
        // rise wait that runs out.
        program_ranger(1'b1, 2, 3, 1, 0, 1);
        send_pattern(16'b0011100000000, 13);
        settle();

        // Minimum above maximum: every finished measurement is an error.
        program_ranger(1'b1, 1, 2, 0, 3, 1);
        send_pattern(16'b001010, 6);
        settle();

        // Disable in the middle of a trigger pulse: abort with no result, status outputs hold.
        program_ranger(1'b1, 5, 10, 0, 0, 255);
        send_pattern(16'b00, 2);
        settle();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1'b0), 1'b1);
        send_pattern(16'b10, 2);
        settle();

        // ---- Random part ---------------------------------------------------------
        // Each phase picks a setting, sweeps the idling mode, and drives echo as
        // pulse trains shaped to the timeout so that most measurements complete.
        // The first phases each force one extreme setting.
        phase_no     = 0;
        random_start = ticks_sent;
        while (ticks_sent - random_start < 800) begin
            gap_mode <= gap_mode_e'(phase_no % 4);
            en     = 1'b1;
            trig   = $urandom_range(1, 6);
            tmo    = $urandom_range(2, 60);
            period = $urandom_range(0, 80);
            min_cm = $urandom_range(0, 1);
            max_cm = $urandom_range(0, 2);
            kind   = (phase_no < 7) ? phase_no : $urandom_range(9);
            case (kind)
                0: trig = 255;
                1: period = int'(PERIOD_MAX);
                2: begin
                    min_cm = 255;
                    max_cm = 255;
                end
                3: begin
                    min_cm = $urandom_range(2, 255);
                    max_cm = $urandom_range(0, min_cm - 1);
                end
                4: en = 1'b0;
                5: tmo = $urandom_range(0, 1);
                6: tmo = 65535;
                default: ;
            endcase
            program_ranger(en, trig, tmo, period, min_cm, max_cm);

            budget      = $urandom_range(60, 150) + trig;
            pulse_cap   = (tmo < 60) ? tmo : 60;
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < budget) begin
                if ($urandom_range(7) == 0) begin
                    // noise: an isolated random level
                    send_tick(1'($urandom_range(1)));
                end else begin
                    send_level(1'b0, $urandom_range(0, pulse_cap + 1));
                    send_level(1'b1, $urandom_range(1, pulse_cap + 1));
                end
            end
            settle();
            phase_no++;
        end

        // ---- Long echo -----------------------------------------------------------
        // Longest timeout and a wide echo measured without gaps.
        gap_mode <= GAP_NONE;
        program_ranger(1'b1, 1, 65535, 0, 0, 255);
        send_level(1'b0, 3);
        send_level(1'b1, 150);
        send_level(1'b0, 3);
        settle();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/uer_pkg.sv
design/uer_ifs.sv
design/ultrasonic_echo_ranger.sv
design/uer_checker.sv
tb/sv/uer_tick_checker.sv
tb/sv/ultrasonic_echo_ranger_tb.sv
